### rtl/hpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

    // Pool geometry, fixed by the slot and count field widths
    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int LINK_W     = 7;
    localparam int HANDLE_W   = 31;
    localparam int COUNT_W    = 7;
    localparam int GEN_W      = HANDLE_W - SLOT_W;

    // Null link of the free list
    localparam logic [LINK_W-1:0]  LINK_NIL  = LINK_W'(POOL_SLOTS);
    localparam logic [COUNT_W-1:0] POOL_FULL = COUNT_W'(POOL_SLOTS);

    // Stream word widths
    localparam int IN_W  = 40;
    localparam int OUT_W = 48;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_SCAN   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_STALE = 2'd2
    } t_status;

    typedef enum logic {
        ALU_INC = 1'b0,
        ALU_DEC = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_WR,
        S_FREE,
        S_LOOKUP,
        S_SCAN,
        S_SCAN_RD
    } t_state;

    // Slot memory access request from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
        logic                h_we;
        logic [SLOT_W-1:0]   h_addr;
        logic [HANDLE_W-1:0] h_data;
        logic                l_we;
        logic [SLOT_W-1:0]   l_addr;
        logic [LINK_W-1:0]   l_data;
    } t_mem_req;

endpackage

`default_nettype wire

### rtl/hpa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module hpa_mem (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire hpa_pkg::t_mem_req            i_req,
    output logic [hpa_pkg::HANDLE_W-1:0]      o_rd_handle,
    output logic [hpa_pkg::LINK_W-1:0]        o_rd_link
);
    import hpa_pkg::*;

    logic [HANDLE_W-1:0]   r_h_mem [POOL_SLOTS];
    logic [LINK_W-1:0]     r_l_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_h_vld;
    logic [POOL_SLOTS-1:0] r_l_vld;
    logic [HANDLE_W-1:0]   r_rd_handle;
    logic [LINK_W-1:0]     r_rd_link;

    // written marks: an unwritten entry reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= '0;
            r_l_vld <= '0;
        end else begin
            if (i_req.h_we) begin
                r_h_vld[i_req.h_addr] <= 1'b1;
            end
            if (i_req.l_we) begin
                r_l_vld[i_req.l_addr] <= 1'b1;
            end
        end
    end

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_req.h_we) begin
            r_h_mem[i_req.h_addr] <= i_req.h_data;
        end
        if (i_req.l_we) begin
            r_l_mem[i_req.l_addr] <= i_req.l_data;
        end
    end

    // registered read: handle resets to zero, link to position + 1
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_handle <= r_h_vld[i_req.rd_addr] ? r_h_mem[i_req.rd_addr] : '0;
            r_rd_link   <= r_l_vld[i_req.rd_addr] ? r_l_mem[i_req.rd_addr]
                                                  : LINK_W'(i_req.rd_addr) + LINK_W'(1);
        end
    end

    assign o_rd_handle = r_rd_handle;
    assign o_rd_link   = r_rd_link;

endmodule

`default_nettype wire

### rtl/hpa_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module hpa_alu (
    input  wire hpa_pkg::t_alu_op           i_op,
    input  wire logic [hpa_pkg::GEN_W-1:0]  i_a,
    output logic [hpa_pkg::GEN_W-1:0]       o_y,
    output logic                            o_carry
);
    import hpa_pkg::*;

    // shared incrementer / decrementer with carry out
    always_comb begin
        case (i_op)
            ALU_INC: {o_carry, o_y} = {1'b0, i_a} + (GEN_W + 1)'(1);
            ALU_DEC: {o_carry, o_y} = {1'b0, i_a} - (GEN_W + 1)'(1);
            default: {o_carry, o_y} = {1'b0, i_a};
        endcase
    end

endmodule

`default_nettype wire

### rtl/handle_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Handle pool allocator: 64 slots on a linked free list, one command per input
// word (allocate, free, look up, scan) and exactly one result word per command.
// Commands run one at a time under a small sequencer that shares a single
// incrementer/decrementer; slot handles and links sit in a memory with a registered
// read port. A new command is accepted only once the last one has returned to idle;
// a scan examines one slot per cycle from scan_start until it finds a used slot or
// passes the last slot. A result waits in an output register, so a stalled master
// side costs nothing until the next result is due. free_order may be written
// only while the block is idle.
module handle_pool_allocator (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // config: free_order
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_wdata,
    // command stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: cmd[1:0], handle_in[32:2], scan_start[38:33], zero pad[39]
    input  wire logic [hpa_pkg::IN_W-1:0]  s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // tdata: status[1:0], handle_out[32:2], slot[38:33], used_count[45:39], zero pad[47:46]
    output logic [hpa_pkg::OUT_W-1:0]      m_axis_tdata
);
    import hpa_pkg::*;

    t_state                r_state, n_state;
    logic [HANDLE_W-1:0]   r_h, n_h;
    logic [LINK_W-1:0]     r_idx, n_idx;
    logic [HANDLE_W-1:0]   r_nh, n_nh;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_tail, n_tail;
    logic [COUNT_W-1:0]    r_in_use, n_in_use;
    logic [POOL_SLOTS-1:0] r_valid, n_valid;
    logic                  r_free_order;
    logic                  r_out_vld, n_out_vld;
    logic [OUT_W-1:0]      r_out_data, n_out_data;

    t_mem_req              mem_req;
    logic [HANDLE_W-1:0]   rd_handle;
    logic [LINK_W-1:0]     rd_link;
    t_alu_op               alu_op;
    logic [GEN_W-1:0]      alu_a, alu_y;
    logic                  alu_carry;

    t_cmd                  in_cmd;
    logic [HANDLE_W-1:0]   in_h;
    logic [SLOT_W-1:0]     in_start;
    logic                  s_acc, out_free, handle_ok, exhausted;
    logic [SLOT_W-1:0]     pos, head_pos;
    logic                  res_load;
    t_status               res_status;
    logic [HANDLE_W-1:0]   res_handle;
    logic [SLOT_W-1:0]     res_slot;
    logic [COUNT_W-1:0]    res_count;

    hpa_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_rd_handle (rd_handle),
        .o_rd_link   (rd_link)
    );

    hpa_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .o_y     (alu_y),
        .o_carry (alu_carry)
    );

    // input word fields
    assign in_cmd   = t_cmd'(s_axis_tdata[1:0]);
    assign in_h     = s_axis_tdata[32:2];
    assign in_start = s_axis_tdata[38:33];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign pos       = r_h[SLOT_W-1:0];
    assign head_pos  = r_head[SLOT_W-1:0];
    assign handle_ok = r_valid[pos] && (rd_handle == r_h);
    assign exhausted = (r_in_use >= POOL_FULL) || (r_head >= LINK_NIL);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_free_order <= i_cfg_wdata;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= LINK_W'(POOL_SLOTS - 1);
            r_in_use  <= '0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_in_use  <= n_in_use;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_idx      <= n_idx;
        r_nh       <= n_nh;
        r_out_data <= n_out_data;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_h        = r_h;
        n_idx      = r_idx;
        n_nh       = r_nh;
        n_head     = r_head;
        n_tail     = r_tail;
        n_in_use   = r_in_use;
        n_valid    = r_valid;
        mem_req    = '0;
        alu_op     = ALU_INC;
        alu_a      = '0;
        res_load   = 1'b0;
        res_status = ST_OK;
        res_handle = '0;
        res_slot   = '0;
        res_count  = r_in_use;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_h             = in_h;
                    n_idx           = {1'b0, in_start};
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = (in_cmd == CMD_ALLOC) ? head_pos : in_h[SLOT_W-1:0];
                    case (in_cmd)
                        CMD_ALLOC:  n_state = S_ALLOC;
                        CMD_FREE:   n_state = S_FREE;
                        CMD_LOOKUP: n_state = S_LOOKUP;
                        CMD_SCAN:   n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            // next generation: bump the bits above the position, wrap on overflow
            S_ALLOC: begin
                alu_op = ALU_INC;
                alu_a  = rd_handle[HANDLE_W-1:SLOT_W];
                if (exhausted) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res_status = ST_NONE;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_nh    = (rd_handle == '0 || alu_carry) ? HANDLE_W'(head_pos)
                                                            : {alu_y, head_pos};
                    n_state = S_ALLOC_WR;
                end
            end

            // commit allocation and pop the list head
            S_ALLOC_WR: begin
                alu_op = ALU_INC;
                alu_a  = GEN_W'(r_in_use);
                if (out_free) begin
                    mem_req.h_we      = 1'b1;
                    mem_req.h_addr    = head_pos;
                    mem_req.h_data    = r_nh;
                    n_valid[head_pos] = 1'b1;
                    n_in_use          = alu_y[COUNT_W-1:0];
                    if (r_head == r_tail) begin
                        n_head = LINK_NIL;
                        n_tail = LINK_NIL;
                    end else begin
                        n_head = rd_link;
                    end
                    res_load   = 1'b1;
                    res_handle = r_nh;
                    res_slot   = head_pos;
                    res_count  = alu_y[COUNT_W-1:0];
                    n_state    = S_IDLE;
                end
            end

            // free: return a live slot at head or tail of the list; a stale handle is refused
            S_FREE: begin
                alu_op = ALU_DEC;
                alu_a  = GEN_W'(r_in_use);
                if (out_free) begin
                    res_load = 1'b1;
                    res_slot = pos;
                    n_state  = S_IDLE;
                    if (!handle_ok) begin
                        res_status = ST_STALE;
                    end else begin
                        n_valid[pos] = 1'b0;
                        n_in_use     = alu_y[COUNT_W-1:0];
                        res_count    = alu_y[COUNT_W-1:0];
                        if (r_free_order) begin
                            mem_req.l_we   = 1'b1;
                            mem_req.l_addr = pos;
                            mem_req.l_data = r_head;
                            if (r_head >= LINK_NIL) begin
                                n_tail = LINK_W'(pos);
                            end
                            n_head = LINK_W'(pos);
                        end else begin
                            if (r_tail >= LINK_NIL) begin
                                n_head = LINK_W'(pos);
                            end else begin
                                mem_req.l_we   = 1'b1;
                                mem_req.l_addr = r_tail[SLOT_W-1:0];
                                mem_req.l_data = LINK_W'(pos);
                            end
                            n_tail = LINK_W'(pos);
                        end
                    end
                end
            end

            S_LOOKUP: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    res_slot   = pos;
                    res_status = handle_ok ? ST_OK : ST_STALE;
                    res_handle = handle_ok ? rd_handle : '0;
                    n_state    = S_IDLE;
                end
            end

            // walk one slot per cycle until a used one turns up or the pool end is passed
            S_SCAN: begin
                alu_op = ALU_INC;
                alu_a  = GEN_W'(r_idx);
                if (r_idx >= LINK_W'(POOL_SLOTS)) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res_status = ST_NONE;
                        n_state    = S_IDLE;
                    end
                end else if (r_valid[r_idx[SLOT_W-1:0]]) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx[SLOT_W-1:0];
                    n_state         = S_SCAN_RD;
                end else begin
                    n_idx = alu_y[LINK_W-1:0];
                end
            end

            S_SCAN_RD: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    res_handle = rd_handle;
                    res_slot   = r_idx[SLOT_W-1:0];
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        if (res_load) begin
            n_out_vld  = 1'b1;
            n_out_data = {2'b00, res_count, res_slot, res_handle, res_status};
        end
    end

    // bookkeeping checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= POOL_FULL)
        else $error("used count above pool size");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_in_use))
        else $error("used count disagrees with valid marks");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == LINK_NIL) == (r_tail == LINK_NIL))
        else $error("free list head and tail disagree on empty");

    a_no_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !res_load)
        else $error("result produced with no command in progress");

    a_full_no_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use == POOL_FULL) |-> (r_head == LINK_NIL))
        else $error("free list not empty with pool full");

endmodule

`default_nettype wire

### bench/handle_pool_allocator_tb.sv
`timescale 1ns / 1ps

import hpa_pkg::*;

// One expected result word
typedef struct {
    t_status             status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  used;
} t_pool_result;

// Mirror of the slot pool: predicts each result and checks what comes back
class pool_scoreboard;
    bit                  order_lifo;
    bit                  slot_valid  [POOL_SLOTS];
    logic [HANDLE_W-1:0] slot_handle [POOL_SLOTS];
    logic [LINK_W-1:0]   next_link   [POOL_SLOTS];
    logic [LINK_W-1:0]   free_head;
    logic [LINK_W-1:0]   free_tail;
    logic [COUNT_W-1:0]  in_use;
    t_pool_result        expected_results[$];
    int                  mismatches;
    int                  cmd_seen    [4];
    int                  status_seen [3];

    function new();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_valid[i]  = 1'b0;
            slot_handle[i] = '0;
            next_link[i]   = LINK_W'(i + 1);
        end
        order_lifo = 1'b0;
        free_head  = '0;
        free_tail  = LINK_W'(POOL_SLOTS - 1);
        in_use     = '0;
        mismatches = 0;
    endfunction

    function bit handle_matches(logic [HANDLE_W-1:0] h);
        return slot_valid[h[SLOT_W-1:0]] && slot_handle[h[SLOT_W-1:0]] == h;
    endfunction

    // Work out the result of an accepted command word and update the pool
    function void note_command(t_cmd cmd, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] start);
        t_pool_result     r;
        logic [SLOT_W-1:0] pos;
        logic [HANDLE_W:0] nh;
        bit               found;
        r.status = ST_OK;
        r.handle = '0;
        r.slot   = h[SLOT_W-1:0];
        pos      = h[SLOT_W-1:0];
        found    = 1'b0;
        cmd_seen[cmd]++;
        case (cmd)
            CMD_ALLOC: begin
                if (in_use >= POOL_FULL || free_head >= LINK_NIL) begin
                    r.status = ST_NONE;
                    r.slot   = '0;
                end else begin
                    pos = free_head[SLOT_W-1:0];
                    if (slot_handle[pos] == '0) begin
                        nh = (HANDLE_W+1)'(pos);
                    end else begin
                        // next generation, rounded to the pool size
                        nh = {1'b0, slot_handle[pos][HANDLE_W-1:SLOT_W], SLOT_W'(0)}
                             + (HANDLE_W+1)'(POOL_SLOTS) + (HANDLE_W+1)'(pos);
                        if (nh > (HANDLE_W+1)'(32'h7FFF_FFFF))
                            nh = (HANDLE_W+1)'(pos);
                    end
                    free_head = next_link[pos];
                    if (free_head >= LINK_NIL) begin
                        free_head = LINK_NIL;
                        free_tail = LINK_NIL;
                    end
                    slot_valid[pos]  = 1'b1;
                    slot_handle[pos] = nh[HANDLE_W-1:0];
                    in_use++;
                    r.handle = nh[HANDLE_W-1:0];
                    r.slot   = pos;
                end
            end
            CMD_FREE: begin
                if (!handle_matches(h)) begin
                    r.status = ST_STALE;
                end else begin
                    slot_valid[pos] = 1'b0;
                    in_use--;
                    if (order_lifo) begin
                        next_link[pos] = free_head;
                        if (free_head >= LINK_NIL)
                            free_tail = LINK_W'(pos);
                        free_head = LINK_W'(pos);
                    end else begin
                        next_link[pos] = LINK_NIL;
                        if (free_tail >= LINK_NIL)
                            free_head = LINK_W'(pos);
                        else
                            next_link[free_tail[SLOT_W-1:0]] = LINK_W'(pos);
                        free_tail = LINK_W'(pos);
                    end
                end
            end
            CMD_LOOKUP: begin
                if (!handle_matches(h))
                    r.status = ST_STALE;
                else
                    r.handle = slot_handle[pos];
            end
            default: begin
                // first used slot at or after start
                for (int i = start; i < POOL_SLOTS; i++) begin
                    if (!found && slot_valid[i]) begin
                        found    = 1'b1;
                        r.handle = slot_handle[i];
                        r.slot   = SLOT_W'(i);
                    end
                end
                if (!found) begin
                    r.status = ST_NONE;
                    r.slot   = '0;
                end
            end
        endcase
        r.used = in_use;
        expected_results.push_back(r);
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    // Compare a result word with the oldest expectation
    task check_result(logic [OUT_W-1:0] w);
        t_pool_result want;
        if (expected_results.size() == 0) begin
            report("result word with nothing pending", w, 0);
            return;
        end
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (w[1:0] != want.status)
            report("status", w[1:0], want.status);
        if (w[32:2] != want.handle)
            report("handle_out", w[32:2], want.handle);
        if (w[38:33] != want.slot)
            report("slot", w[38:33], want.slot);
        if (w[45:39] != want.used)
            report("used_count", w[45:39], want.used);
    endtask

    // Handle of a random used slot, if any
    function bit pick_live(output logic [HANDLE_W-1:0] h);
        int live[$];
        h = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
            if (slot_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return 1'b0;
        h = slot_handle[live[$urandom_range(0, live.size() - 1)]];
        return 1'b1;
    endfunction

    // Mostly wrong handles: random, stale, a future generation, or one bit off
    function logic [HANDLE_W-1:0] stray_handle();
        logic [HANDLE_W-1:0] h;
        h = slot_handle[$urandom_range(0, POOL_SLOTS - 1)];
        case ($urandom_range(0, 3))
            0: h = HANDLE_W'($urandom);
            1: h = h;
            2: h = h + HANDLE_W'(POOL_SLOTS);
            default: h = h ^ (HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1));
        endcase
        return h;
    endfunction
endclass

module handle_pool_allocator_tb;

    localparam int SETTLE_CYCLES = 80;
    localparam int STUCK_LIMIT   = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // cmd, handle_in, scan_start, pad
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // status, handle_out, slot, used_count, pad

    pool_scoreboard sb;
    int             send_idle;
    int             recv_idle;
    int             stuck_cycles;

    handle_pool_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Present one command word and hold it until accepted
    task automatic send_command(t_cmd cmd, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] start);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, start, h, cmd};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_command(cmd, h, start);
    endtask

    // Stop sending and wait until every pending result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_free_order(bit lifo);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lifo;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.order_lifo = lifo;
    endtask

    // Mostly well-formed traffic from live handles, some stray handles
    task automatic random_command(int alloc_pct, int free_pct);
        int                  roll;
        bit                  have;
        logic [HANDLE_W-1:0] h;
        roll = $urandom_range(0, 99);
        have = sb.pick_live(h);
        if (!have || $urandom_range(0, 9) == 0)
            h = sb.stray_handle();
        if (roll < alloc_pct)
            send_command(CMD_ALLOC, HANDLE_W'($urandom), SLOT_W'($urandom));
        else if (roll < alloc_pct + free_pct)
            send_command(CMD_FREE, h, SLOT_W'($urandom));
        else if ($urandom_range(0, 99) < 55)
            send_command(CMD_LOOKUP, h, SLOT_W'($urandom));
        else
            send_command(CMD_SCAN, HANDLE_W'($urandom), SLOT_W'($urandom));
    endtask

    initial begin
        sb = new();
        send_idle     = 28;
        recv_idle     = 50;
        stuck_cycles  = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pool, handle zero reuse, generations, both orders
        set_free_order(1'b1);
        send_command(CMD_LOOKUP, '0, '0);
        send_command(CMD_FREE, 31'h7FFF_FFFF, 6'h3F);
        send_command(CMD_SCAN, '0, '0);
        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_LOOKUP, '0, '0);
        send_command(CMD_SCAN, '1, '0);
        send_command(CMD_FREE, '0, '0);
        send_command(CMD_FREE, '0, '0);
        send_command(CMD_ALLOC, '1, '1);
        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_FREE, 31'd1, '0);
        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_LOOKUP, 31'd1, '0);
        send_command(CMD_LOOKUP, 31'd65, '0);
        send_command(CMD_SCAN, '0, 6'h3F);
        send_command(CMD_SCAN, '0, 6'd1);
        send_command(CMD_LOOKUP, 31'h7FFF_FFC1, '0);
        set_free_order(1'b0);
        send_command(CMD_FREE, 31'd65, '0);
        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_FREE, '0, '0);
        send_command(CMD_SCAN, '0, '0);

        // Random: fill to exhaustion, drain, then mixed, per flow-control mix
        for (int p = 0; p < 6; p++) begin
            send_idle = (p / 2 == 0) ? 28 : (p / 2 == 1) ? 50 : 0;
            recv_idle = (p / 2 == 0) ? 50 : (p / 2 == 1) ? 28 : 0;
            set_free_order(p % 2 == 0);
            repeat (100) random_command(80, 5);
            drain_results();
            repeat (100) random_command(5, 80);
            repeat (70) random_command(35, 30);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d allocates, %0d frees, %0d lookups, %0d scans, both free orders",
                 sb.cmd_seen[CMD_ALLOC], sb.cmd_seen[CMD_FREE], sb.cmd_seen[CMD_LOOKUP],
                 sb.cmd_seen[CMD_SCAN]);
        $display("answers: %0d ok, %0d exhausted or not found, %0d stale; %0d mismatches",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NONE], sb.status_seen[ST_STALE],
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
